// ----- hdl/ncwu_pkg.sv -----
// Package: shared types, constants and the log2 / exp2 tables for the weight update.
package ncwu_pkg;

  localparam int unsigned TabN    = 256;
  localparam int unsigned TabBits = $clog2(TabN);
  localparam logic [31:0] MinInit = 32'h7FFF_FFFF;
  localparam logic [33:0] One30   = 34'h0_4000_0000;

  typedef enum logic [1:0] {
    REG_WNS    = 2'd0,
    REG_DECAY  = 2'd1,
    REG_MAXW   = 2'd2,
    REG_DEGLIM = 2'd3
  } reg_idx_t;

  // One finished net handed from the pin front end to the math back end.
  typedef struct packed {
    logic [31:0] slack;
    logic [31:0] crit;
    logic [31:0] weight;
    logic [15:0] degree;
  } net_job_t;

  typedef struct packed {
    logic [31:0] min_slack;
    logic [31:0] new_criticality;
    logic [31:0] new_weight;
    logic        weight_clamped;
    logic        degree_skipped;
  } net_res_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n, res, bit_v;
    n     = n_in;
    res   = '0;
    bit_v = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > n) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] log_entry(input int unsigned i);
    logic [63:0] z, y, f;
    f = (64'(i) << 30) / 64'(TabN);
    z = 64'h4000_0000 + f;
    y = '0;
    if (z >= 64'h8000_0000) return 32'h4000_0000;
    for (int b = 29; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= 64'h8000_0000) begin
        z = z >> 1;
        y = y + (64'h1 << b);
      end
    end
    return y[31:0];
  endfunction

  function automatic logic [31:0] exp_entry(input int unsigned i);
    logic [63:0] roots [31];
    logic [63:0] f, p;
    if (i == TabN) return 32'h8000_0000;
    roots[0] = 64'h8000_0000;
    for (int k = 1; k <= 30; k++) roots[k] = isqrt64(roots[k-1] << 30);
    f = (64'(i) << 30) / 64'(TabN);
    p = 64'h4000_0000;
    for (int k = 1; k <= 30; k++) begin
      if (f[30-k]) p = (p * roots[k]) >> 30;
    end
    return p[31:0];
  endfunction

endpackage

// ----- hdl/net_criticality_weight_update.sv -----
// Path: a negative slack goes through the divide before the log2/exp2 blend, other slacks skip the divide,
// and when the wns register is not negative only the weight update runs; output stalls hold the result.
// Throughput: one pin per cycle while in_tready is high; the back end takes a new net only when idle.
// Front end keeps taking pins until three finished nets wait (two in the queue plus its own register).
// Reset (rst_n low, synchronous): registers to defaults, running minimum to max slack.
module net_criticality_weight_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slack_rise[31:0], slack_fall[63:32], pin_valid[64], old_criticality[96:65],
  // old_weight[128:97], net_degree[144:129], zero pad [151:145]
  input  logic [151:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // min_slack[31:0], new_criticality[63:32], new_weight[95:64]
  output logic [95:0] out_tdata,
  // weight_clamped[0], degree_skipped[1]
  output logic [1:0]  out_tuser
);
  import ncwu_pkg::*;

  logic [31:0] wns_r, maxw_r;
  logic [15:0] decay_r, deglim_r;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  net_job_t    fj, bj;
  net_res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wns_r    <= '0;
      decay_r  <= 16'd32768;
      maxw_r   <= 32'hFFFF_FFFF;
      deglim_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WNS:    wns_r    <= cfg_data;
        REG_DECAY:  decay_r  <= cfg_data[15:0];
        REG_MAXW:   maxw_r   <= cfg_data;
        REG_DEGLIM: deglim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ncwu_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .slack_rise(in_tdata[31:0]), .slack_fall(in_tdata[63:32]), .pin_valid(in_tdata[64]),
    .last_pin(in_tlast), .old_crit(in_tdata[96:65]), .old_weight(in_tdata[128:97]),
    .degree(in_tdata[144:129]), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  ncwu_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  ncwu_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .wns(wns_r), .decay(decay_r), .max_w(maxw_r), .deg_lim(deglim_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {res.new_weight, res.new_criticality, res.min_slack};
  assign out_tuser = {res.degree_skipped, res.weight_clamped};

  a_skip_noclamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0]) else $error("skipped net clamped");
  a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:64] == maxw_r) else $error("clamp value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
endmodule

// ----- hdl/ncwu_front.sv -----
// Front end: running minimum over pins, emits one job per net on the last pin.
module ncwu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        slack_rise,
  input  logic [31:0]        slack_fall,
  input  logic               pin_valid,
  input  logic               last_pin,
  input  logic [31:0]        old_crit,
  input  logic [31:0]        old_weight,
  input  logic [15:0]        degree,
  output logic               job_valid,
  input  logic               job_ready,
  output ncwu_pkg::net_job_t job
);
  import ncwu_pkg::*;

  logic [31:0] min_r, min_nxt;
  logic        job_valid_r;
  net_job_t    job_r;
  logic [31:0] pin_min, cur;
  logic        acc;

  assign in_ready  = !job_valid_r || job_ready;
  assign acc       = in_valid && in_ready;
  assign pin_min   = ($signed(slack_rise) < $signed(slack_fall)) ? slack_rise : slack_fall;
  assign cur       = (pin_valid && $signed(pin_min) < $signed(min_r)) ? pin_min : min_r;
  assign min_nxt   = last_pin ? MinInit : cur;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MinInit;
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= (acc && last_pin) || (job_valid_r && !job_ready);
      if (acc) begin
        min_r <= min_nxt;
        if (last_pin) begin
          job_r <= '{slack: cur, crit: old_crit, weight: old_weight, degree: degree};
        end
      end
    end
  end
endmodule

// ----- hdl/ncwu_fifo.sv -----
// Short job queue between front and back end.
module ncwu_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  ncwu_pkg::net_job_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output ncwu_pkg::net_job_t rd_data
);
  import ncwu_pkg::*;

  net_job_t    mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ----- hdl/ncwu_back.sv -----
// Back end: divider, table log2/exp2 blend, weight multiply and clamp sequencer.
module ncwu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  ncwu_pkg::net_job_t job,
  input  logic [31:0]        wns,
  input  logic [15:0]        decay,
  input  logic [31:0]        max_w,
  input  logic [15:0]        deg_lim,
  output logic               res_valid,
  input  logic               res_ready,
  output ncwu_pkg::net_res_t res
);
  import ncwu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_LOGA, S_LOGB, S_BLEND, S_EXPA, S_EXPB, S_W1, S_W2, S_W3
  } st_t;

  st_t         st_r;
  net_job_t    j_r;
  logic [31:0] wns_r;
  logic [5:0]  dcnt_r;
  logic [62:0] rem_r;
  logic [62:0] q_r;
  logic [31:0] den_r;
  logic [33:0] arg_r;    // log argument Q4.30
  logic [1:0]  e_r;
  logic [31:0] lc_r, ln_r, l_r;
  logic [31:0] lo_r, diff_r;
  logic [29:0] rem30_r;
  logic        tsel_r;   // 0 log table, 1 exp table
  logic        second_r;
  logic [1:0]  k_r;
  logic [35:0] e_val_r;
  logic [31:0] crit_r;
  logic [48:0] a_r;
  logic [47:0] b_r;
  logic        res_valid_r;
  net_res_t    res_r;
  logic        res_load;

  logic [31:0] log_tab [TabN+1];
  logic [31:0] exp_tab [TabN+1];
  for (genvar g = 0; g <= TabN; g++) begin : g_tab
    assign log_tab[g] = log_entry(g);
    assign exp_tab[g] = exp_entry(g);
  end

  // Table lookup from a Q0.30 fraction.
  logic [29:0]        frac;
  logic [37:0]        pos;
  logic [TabBits-1:0] idx;
  logic [TabBits:0]   idx_lo, idx_hi;
  logic [31:0]        t_lo, t_hi;
  assign pos    = 38'(frac) * 38'(TabN);
  assign idx    = pos[30 +: TabBits];
  assign idx_lo = {1'b0, idx};
  assign idx_hi = idx_lo + (TabBits+1)'(1);
  assign t_lo   = tsel_r ? exp_tab[idx_lo] : log_tab[idx_lo];
  assign t_hi   = tsel_r ? exp_tab[idx_hi] : log_tab[idx_hi];

  logic [33:0] arg_sh;
  logic [1:0]  e_c;
  always_comb begin
    e_c = 2'd0;
    if (arg_r >= 34'h0_8000_0000) e_c = 2'd1;
    if ((arg_r >> 1) >= 34'h0_8000_0000) e_c = 2'd2;
    arg_sh = arg_r >> e_c;
    frac   = tsel_r ? l_r[29:0] : 30'(arg_sh - One30);
  end

  logic [61:0] prod;
  assign prod = 62'(diff_r) * 62'(rem30_r);
  logic [32:0] interp;
  assign interp = 33'(lo_r) + 33'(prod >> 30);

  logic [63:0] trial;
  assign trial = {rem_r, q_r[62]} - {32'd0, den_r};

  logic [47:0] blend;
  assign blend = 48'(decay) * 48'(lc_r) + (48'd65536 - 48'(decay)) * 48'(ln_r);

  logic [33:0] x;
  assign x = 34'(crit_r) + One30;
  logic [48:0] nw;
  assign nw = 49'(a_r >> 14)
              + 49'(((({35'd0, a_r[13:0]} << 16) + 49'(b_r)) >> 30));

  assign job_ready = st_r == S_IDLE;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  // Load a new result only once the previous beat has left.
  assign res_load  = (st_r == S_W3) && (!res_valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_load || (res_valid_r && !res_ready);
      case (st_r)
        S_IDLE: if (job_valid) begin
          j_r    <= job;
          wns_r  <= wns;
          crit_r <= job.crit;
          q_r    <= '0;
          dcnt_r <= 6'd0;
          den_r  <= 32'(-$signed({wns[31], wns}));
          rem_r  <= ($signed(wns) < 0 && $signed(job.slack) < 0)
                    ? 63'(-$signed({job.slack[31], job.slack})) : '0;
          if ($signed(wns) < 0) begin
            st_r <= $signed(job.slack) < 0 ? S_DIV : S_LOGA;
            arg_r  <= 34'(job.crit) + One30;
            tsel_r <= 1'b0;
            second_r <= 1'b0;
          end else begin
            st_r <= S_W1;
          end
        end
        S_DIV: begin
          // Restoring divide of (num<<30)/den, one quotient bit a cycle, 63 bits.
          if (dcnt_r == 6'd0) begin
            rem_r  <= '0;
            q_r    <= rem_r << 30;
            dcnt_r <= 6'd1;
          end else begin
            if (!trial[63]) begin
              rem_r <= trial[62:0];
              q_r   <= {q_r[61:0], 1'b1};
            end else begin
              rem_r <= {rem_r[61:0], q_r[62]};
              q_r   <= {q_r[61:0], 1'b0};
            end
            if (dcnt_r == 6'd63) begin
              st_r <= S_LOGA;
            end
            dcnt_r <= dcnt_r + 6'd1;
          end
        end
        S_LOGA: begin
          e_r     <= e_c;
          lo_r    <= t_lo;
          diff_r  <= (t_hi > t_lo) ? t_hi - t_lo : 32'd0;
          rem30_r <= pos[29:0];
          st_r    <= S_LOGB;
        end
        S_LOGB: begin
          if (!second_r) begin
            lc_r     <= {e_r, 30'd0} + interp[31:0];
            second_r <= 1'b1;
            arg_r    <= ($signed(j_r.slack) < 0)
                        ? ((q_r > 63'hFFFF_FFFF) ? 34'h0_FFFF_FFFF : 34'(q_r[31:0])) + One30
                        : One30;
            st_r     <= S_LOGA;
          end else begin
            ln_r <= {e_r, 30'd0} + interp[31:0];
            st_r <= S_BLEND;
          end
        end
        S_BLEND: begin
          l_r    <= blend[47:16];
          tsel_r <= 1'b1;
          st_r   <= S_EXPA;
        end
        S_EXPA: begin
          k_r     <= l_r[31:30];
          lo_r    <= t_lo;
          diff_r  <= (t_hi > t_lo) ? t_hi - t_lo : 32'd0;
          rem30_r <= pos[29:0];
          st_r    <= S_EXPB;
        end
        S_EXPB: begin
          e_val_r <= 36'(interp) << k_r;
          st_r    <= S_W1;
        end
        S_W1: begin
          if ($signed(wns_r) < 0) begin
            if (e_val_r <= 36'(One30)) crit_r <= '0;
            else if (e_val_r - 36'(One30) > 36'h0_FFFF_FFFF) crit_r <= 32'hFFFF_FFFF;
            else crit_r <= 32'(e_val_r - 36'(One30));
          end
          st_r <= S_W2;
        end
        S_W2: begin
          a_r  <= 49'(j_r.weight) * 49'(x[33:16]);
          b_r  <= 48'(j_r.weight) * 48'(x[15:0]);
          st_r <= S_W3;
        end
        S_W3: if (res_load) begin
          res_r.min_slack       <= j_r.slack;
          res_r.new_criticality <= crit_r;
          if (j_r.degree > deg_lim) begin
            res_r.new_weight     <= j_r.weight;
            res_r.weight_clamped <= 1'b0;
            res_r.degree_skipped <= 1'b1;
          end else begin
            res_r.degree_skipped <= 1'b0;
            res_r.weight_clamped <= nw > 49'(max_w);
            res_r.new_weight     <= (nw > 49'(max_w)) ? max_w : nw[31:0];
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sim/testbench.sv -----
// Testbench for the net criticality and weight update block: scoreboard and stimulus.
`timescale 1ns / 1ps

module testbench;
  import ncwu_pkg::*;

  class crit_scoreboard;
    logic [31:0]        log_tab [TabN+1];
    logic [31:0]        exp_tab [TabN+1];
    logic signed [63:0] wns;
    logic [63:0]        decay;
    logic [63:0]        max_w;
    logic [63:0]        deg_lim;
    logic signed [63:0] run_min;
    net_res_t           pending_nets [$];
    int                 errors;

    function new();
      logic [63:0] roots [31];
      logic [63:0] f, p, z, y;
      roots[0] = 64'h8000_0000;
      for (int k = 1; k <= 30; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      for (int i = 0; i <= TabN; i++) begin
        f = (64'(i) << 30) / 64'(TabN);
        // log2 of 1+f by repeated squaring
        z = 64'h4000_0000 + f;
        y = 0;
        if (z >= 64'h8000_0000) y = 64'h4000_0000;
        else begin
          for (int b = 29; b >= 0; b--) begin
            z = (z * z) >> 30;
            if (z >= 64'h8000_0000) begin
              z = z >> 1;
              y = y + (64'h1 << b);
            end
          end
        end
        log_tab[i] = y[31:0];
        p = 64'h4000_0000;
        for (int k = 1; k <= 30; k++) if (f[30-k]) p = (p * roots[k]) >> 30;
        exp_tab[i] = (i == TabN) ? 32'h8000_0000 : p[31:0];
      end
      wns     = 0;
      decay   = 32768;
      max_w   = 64'hFFFF_FFFF;
      deg_lim = 65535;
      run_min = 64'h7FFF_FFFF;
      errors  = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n_in);
      logic [63:0] n, res, b;
      n = n_in;
      res = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else res = res >> 1;
        b = b >> 2;
      end
      return res;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_WNS:    wns = 64'(signed'(v));
        REG_DECAY:  decay = 64'(v[15:0]);
        REG_MAXW:   max_w = 64'(v);
        REG_DEGLIM: deg_lim = 64'(v[15:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] interp(bit use_exp, logic [63:0] frac);
      logic [63:0] pos, idx, rem, lo, hi, diff;
      pos = (frac & 64'h3FFF_FFFF) * 64'(TabN);
      idx = pos >> 30;
      rem = pos & 64'h3FFF_FFFF;
      if (idx >= 64'(TabN)) idx = 64'(TabN) - 1;
      lo = use_exp ? exp_tab[idx] : log_tab[idx];
      hi = use_exp ? exp_tab[idx+1] : log_tab[idx+1];
      diff = (hi > lo) ? hi - lo : 0;
      return lo + ((diff * rem) >> 30);
    endfunction

    function logic [63:0] tab_log2(logic [63:0] x_in);
      logic [63:0] x, e;
      x = x_in;
      e = 0;
      if (x < 64'h4000_0000) x = 64'h4000_0000;
      while (e < 2 && (x >> e) >= 64'h8000_0000) e++;
      return (e << 30) + interp(0, (x >> e) - 64'h4000_0000);
    endfunction

    // Track the running minimum on every pin and predict the result of a net on its last pin.
    function void note_pin(logic [151:0] d, logic last);
      logic signed [63:0] sr, sf, pmin, slack;
      logic [63:0] crit, w, nw, nc, lc, ln, l, e, x, a;
      net_res_t r;
      sr = 64'(signed'(d[31:0]));
      sf = 64'(signed'(d[63:32]));
      if (d[64]) begin
        pmin = (sr < sf) ? sr : sf;
        if (pmin < run_min) run_min = pmin;
      end
      if (!last) return;
      slack = run_min;
      run_min = 64'h7FFF_FFFF;
      crit = 64'(d[96:65]);
      w = 64'(d[128:97]);
      r = '0;
      if (wns < 0) begin
        nc = 0;
        if (slack < 0) begin
          nc = (64'(-slack) << 30) / 64'(-wns);
          if (nc > 64'hFFFF_FFFF) nc = 64'hFFFF_FFFF;
        end
        lc = tab_log2(crit + 64'h4000_0000);
        ln = tab_log2(nc + 64'h4000_0000);
        l = (decay * lc + (65536 - decay) * ln) >> 16;
        e = interp(1, l & 64'h3FFF_FFFF) << ((l >> 30) & 3);
        crit = (e > 64'h4000_0000) ? e - 64'h4000_0000 : 0;
        if (crit > 64'hFFFF_FFFF) crit = 64'hFFFF_FFFF;
      end
      if (64'(d[144:129]) > deg_lim) begin
        r.degree_skipped = 1;
        nw = w;
      end else begin
        x = crit + 64'h4000_0000;
        a = w * (x >> 16);
        nw = (a >> 14) + ((((a & 64'h3FFF) << 16) + w * (x & 64'hFFFF)) >> 30);
        if (nw > max_w) begin
          nw = max_w;
          r.weight_clamped = 1;
        end
      end
      r.min_slack = slack[31:0];
      r.new_criticality = crit[31:0];
      r.new_weight = nw[31:0];
      pending_nets.push_back(r);
    endfunction

    function void check(logic [95:0] d, logic [1:0] u);
      net_res_t want;
      if (pending_nets.size() == 0) begin
        $error("result beat with no net pending: %h %h", d, u);
        errors++;
        return;
      end
      want = pending_nets.pop_front();
      if (d[31:0] !== want.min_slack) begin
        $error("min_slack expected %h actual %h", want.min_slack, d[31:0]);
        errors++;
      end
      if (d[63:32] !== want.new_criticality) begin
        $error("new_criticality expected %h actual %h", want.new_criticality, d[63:32]);
        errors++;
      end
      if (d[95:64] !== want.new_weight) begin
        $error("new_weight expected %h actual %h", want.new_weight, d[95:64]);
        errors++;
      end
      if (u[0] !== want.weight_clamped) begin
        $error("weight_clamped expected %b actual %b", want.weight_clamped, u[0]);
        errors++;
      end
      if (u[1] !== want.degree_skipped) begin
        $error("degree_skipped expected %b actual %b", want.degree_skipped, u[1]);
        errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 800000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = REG_WNS;
  logic [31:0]  cfg_data = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [151:0] in_tdata = 0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  crit_scoreboard sb = new();
  int  cycles = 0;
  int  burst_left = 0;
  int  pins_sent = 0;
  int  stall_mode = 0;
  int  stall_cnt = 0;
  logic signed [31:0] wns_now = 0;

  net_criticality_weight_update dut (.*);

  always #4 clk = ~clk;

  // Sample both channels mid-cycle, where all outputs have settled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pin(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: switch modes now and then, including no stalls.
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(20, 200);
    end else stall_cnt <= stall_cnt - 1;
    case (stall_mode)
      0: out_tready <= 1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (cycles % 7 < 3);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    if (idx == REG_WNS) wns_now = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_pin(logic [31:0] sr, logic [31:0] sf, logic pv, logic last,
                          logic [31:0] crit, logic [31:0] w, logic [15:0] deg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(posedge clk);
        in_tvalid <= 0;
        repeat (gap - 1) @(posedge clk);
      end
    end
    burst_left--;
    @(posedge clk);
    in_tvalid <= 1;
    in_tlast <= last;
    in_tdata <= {7'b0, deg, w, crit, pv, sf, sr};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    pins_sent++;
  endtask

  // Hold until every net result has come back, plus the block's latency.
  task automatic drain();
    @(posedge clk);
    in_tvalid <= 0;
    while (sb.pending_nets.size() != 0) @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_slack();
    int unsigned span;
    span = (wns_now < 0) ? 32'(-wns_now) : 32'h0002_0000;
    if (span > 32'h4000_0000) span = 32'h4000_0000;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return -$urandom_range(0, span * 2);
      2: return $urandom_range(0, span);
      3: return -$urandom_range(0, span / 4);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_crit();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h4000_0000);
      2: return $urandom_range(0, 32'h0100_0000);
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_net();
    int n;
    logic [15:0] deg;
    logic inval;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    inval = ($urandom_range(0, 15) == 0);
    deg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(n);
    for (int i = 0; i < n; i++)
      send_pin(pick_slack(), pick_slack(), inval ? 1'b0 : ($urandom_range(0, 5) != 0),
               1'b0, $urandom, $urandom, 16'($urandom));
    // garbage side fields above were on non-last pins; the last pin carries real ones
    send_pin(pick_slack(), pick_slack(), !inval && $urandom_range(0, 1), 1'b1,
             pick_crit(), $urandom_range(0, 3) ? $urandom_range(0, 32'h0100_0000) : $urandom,
             deg);
  endtask

  task automatic set_all(logic [31:0] wns, logic [31:0] dcy, logic [31:0] mw,
                         logic [31:0] dl);
    write_reg(REG_WNS, wns);
    write_reg(REG_DECAY, dcy);
    write_reg(REG_MAXW, mw);
    write_reg(REG_DEGLIM, dl);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Defaults: no criticality update, only weight scaling.
    send_pin(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_pin(32'h0001_0000, 32'h0002_0000, 0, 1, 32'h0, 32'h0001_0000, 16'hFFFF);
    drain();

    set_all(32'hFFFF_0000, 32'd32768, 32'h0010_0000, 32'd100);
    // no valid pin
    send_pin(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    send_pin(32'h8000_0000, 32'h8000_0000, 0, 1, 32'h1000_0000, 32'h0008_0000, 16'd2);
    // most negative slack saturates the quotient
    send_pin(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'h0008_0000, 16'd1);
    // slack equal to wns, weight already over max
    send_pin(32'hFFFF_0000, 32'h0000_0000, 1, 0, 0, 0, 0);
    send_pin(32'h0001_0000, 32'h7FFF_FFFF, 1, 1, 32'h0, 32'hFFFF_FFFF, 16'd100);
    // degree just over the limit
    send_pin(32'hFFFF_8000, 32'hFFFF_8000, 1, 1, 32'h2000_0000, 32'h0003_0000, 16'd101);
    send_pin(32'h0000_1000, 32'hFFFF_FFFF, 1, 1, 32'h4000_0000, 32'h0000_0001, 16'hFFFF);
    send_pin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 32'h0, 32'h0, 16'd0);
    drain();

    set_all(32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd65535);
    send_pin(32'h8000_0000, 32'h8000_0000, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd5);
    send_pin(32'hC000_0000, 32'h0, 1, 1, 32'h0, 32'h0001_0000, 16'd5);
    drain();
    set_all(32'hFFFF_FFFF, 32'd65535, 32'd0, 32'd0);
    send_pin(32'hFFFF_FFFE, 32'h0, 1, 1, 32'h8000_0000, 32'h0001_0000, 16'd0);
    send_pin(32'h8000_0000, 32'h0, 1, 1, 32'h0, 32'h0001_0000, 16'd1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all(32'hFFF0_0000, 32'd32768, 32'hFFFF_FFFF, 32'd65535);
        1: set_all(32'h0000_0000, $urandom_range(0, 65535), $urandom, 32'd8);
        2: set_all(32'h0001_0000, 32'd0, 32'h0100_0000, 32'd65535);
        3: set_all(32'h8000_0000, 32'd65535, 32'hFFFF_FFFF, 32'd0);
        4: set_all(32'hFFFF_FFFF, 32'd1, 32'h0000_0000, 32'd65535);
        default: set_all(-$urandom_range(1, 32'h7FFF_FFFF), $urandom_range(0, 65535),
                         $urandom, $urandom_range(0, 1) ? 32'd65535 : $urandom_range(0, 16));
      endcase
      pins_sent = 0;
      while (pins_sent < 112) send_net();
      drain();
    end

    if (sb.pending_nets.size() != 0) begin
      $error("%0d net results never arrived", sb.pending_nets.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
